// File: design/tsvt_pkg.sv
// Shared widths, quadrant codes and vector types of the triangle vertex transform.
`default_nettype none

package tsvt_pkg;

  localparam int HEAD_W       = 16;
  localparam int SCALE_W      = 16;
  localparam int PHASE_W      = 32;
  localparam int CORDIC_STEPS = 20;
  localparam int XY_W         = 33;
  localparam int Z_W          = 32;
  localparam int CS_W         = 17;
  localparam int ROT_W        = 32;
  localparam int OFF_W        = ROT_W + SCALE_W + 1;
  localparam int FRAC_W       = 34;
  localparam int VERT_N       = 6;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // Rotated corners in Q2.30, ordered x0, y0, x1, y1, x2, y2.
  typedef logic [VERT_N-1:0][ROT_W-1:0] rot_vec_t;

endpackage

`default_nettype wire

// File: design/tsvt_if.sv
// Valid/ready channel interfaces for the pose input and the vertex output.
`default_nettype none

interface tsvt_in_if import tsvt_pkg::*; #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic [HEAD_W-1:0]            heading;
  logic [SCALE_W-1:0]           scale;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;

  modport source (output valid, heading, scale, pos_x, pos_y, input ready);
  modport sink   (input valid, heading, scale, pos_x, pos_y, output ready);
endinterface

interface tsvt_out_if import tsvt_pkg::*; #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vx0;
  logic signed [COORD_BITS-1:0] vy0;
  logic signed [COORD_BITS-1:0] vx1;
  logic signed [COORD_BITS-1:0] vy1;
  logic signed [COORD_BITS-1:0] vx2;
  logic signed [COORD_BITS-1:0] vy2;

  modport source (output valid, vx0, vy0, vx1, vy1, vx2, vy2, input ready);
  modport sink   (input valid, vx0, vy0, vx1, vy1, vx2, vy2, output ready);
endinterface

`default_nettype wire

// File: design/tsvt_cordic.sv
// Fully pipelined rotation-mode CORDIC, one micro-rotation per register stage.
`default_nettype none

module tsvt_cordic import tsvt_pkg::*; #(
  parameter int SIDE_W = 34
) (
  input  logic                    clk,
  input  logic [CORDIC_STEPS-1:0] ld,
  input  logic signed [Z_W-1:0]   z_in,
  input  logic [SIDE_W-1:0]       side_in,
  output logic signed [XY_W-1:0]  x_out,
  output logic signed [XY_W-1:0]  y_out,
  output logic [SIDE_W-1:0]       side_out
);

  localparam logic signed [XY_W-1:0] CORDIC_START = 33'sd652032874;

  function automatic logic signed [Z_W-1:0] arc_angle(input int step);
    case (step)
      0:       arc_angle = 32'sd536870912;
      1:       arc_angle = 32'sd316933406;
      2:       arc_angle = 32'sd167458907;
      3:       arc_angle = 32'sd85004756;
      4:       arc_angle = 32'sd42667331;
      5:       arc_angle = 32'sd21354465;
      6:       arc_angle = 32'sd10679838;
      7:       arc_angle = 32'sd5340245;
      8:       arc_angle = 32'sd2670163;
      9:       arc_angle = 32'sd1335087;
      10:      arc_angle = 32'sd667544;
      11:      arc_angle = 32'sd333772;
      12:      arc_angle = 32'sd166886;
      13:      arc_angle = 32'sd83443;
      14:      arc_angle = 32'sd41722;
      15:      arc_angle = 32'sd20861;
      16:      arc_angle = 32'sd10430;
      17:      arc_angle = 32'sd5215;
      18:      arc_angle = 32'sd2608;
      19:      arc_angle = 32'sd1304;
      default: arc_angle = '0;
    endcase
  endfunction

  logic signed [XY_W-1:0] x_r    [CORDIC_STEPS];
  logic signed [XY_W-1:0] y_r    [CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_r    [CORDIC_STEPS-1];
  logic [SIDE_W-1:0]      side_r [CORDIC_STEPS];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    logic signed [XY_W-1:0] x_prev;
    logic signed [XY_W-1:0] y_prev;
    logic signed [Z_W-1:0]  z_prev;
    logic [SIDE_W-1:0]      side_prev;
    logic signed [XY_W-1:0] x_nxt;
    logic signed [XY_W-1:0] y_nxt;
    logic                   rot_pos;

    if (g == 0) begin : g_first
      assign x_prev    = CORDIC_START;
      assign y_prev    = '0;
      assign z_prev    = z_in;
      assign side_prev = side_in;
    end else begin : g_next
      assign x_prev    = x_r[g-1];
      assign y_prev    = y_r[g-1];
      assign z_prev    = z_r[g-1];
      assign side_prev = side_r[g-1];
    end

    assign rot_pos = !z_prev[Z_W-1];

    always_comb begin
      if (rot_pos) begin
        x_nxt = x_prev - (y_prev >>> g);
        y_nxt = y_prev + (x_prev >>> g);
      end else begin
        x_nxt = x_prev + (y_prev >>> g);
        y_nxt = y_prev - (x_prev >>> g);
      end
    end

    always_ff @(posedge clk) begin
      if (ld[g]) begin
        x_r[g]    <= x_nxt;
        y_r[g]    <= y_nxt;
        side_r[g] <= side_prev;
      end
    end

    if (g < CORDIC_STEPS - 1) begin : g_angle
      logic signed [Z_W-1:0] z_nxt;

      assign z_nxt = rot_pos ? z_prev - arc_angle(g) : z_prev + arc_angle(g);

      always_ff @(posedge clk) begin
        if (ld[g]) begin
          z_r[g] <= z_nxt;
        end
      end
    end
  end

  assign x_out    = x_r[CORDIC_STEPS-1];
  assign y_out    = y_r[CORDIC_STEPS-1];
  assign side_out = side_r[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// File: design/tsvt_rotate.sv
// Q1.15 rounding with quadrant mapping, then rotation of the three unit-triangle corners.
`default_nettype none

module tsvt_rotate import tsvt_pkg::*; #(
  parameter int SIDE_W = 32
) (
  input  logic                   clk,
  input  logic [2:0]             ld,
  input  logic signed [XY_W-1:0] x_in,
  input  logic signed [XY_W-1:0] y_in,
  input  quad_t                  quad_in,
  input  logic [SIDE_W-1:0]      side_in,
  output rot_vec_t               rot_out,
  output logic [SIDE_W-1:0]      side_out
);

  localparam logic [XY_W-1:0]         ROUND_HALF = XY_W'(1) << 14;
  localparam logic [XY_W-1:0]         MAG_POS    = XY_W'(32767);
  localparam logic [XY_W-1:0]         MAG_NEG    = XY_W'(32768);
  localparam logic signed [CS_W-1:0]  Q15_MAX    = 17'sd32767;
  localparam logic signed [CS_W-1:0]  Q15_MIN    = -17'sd32768;
  localparam logic signed [ROT_W-1:0] ROOT3_HALF = 32'sd28378;

  // Round half away from zero from Q3.30 to Q1.15 and clip to the Q1.15 range.
  function automatic logic signed [CS_W-1:0] round_q15(input logic signed [XY_W-1:0] v);
    logic [XY_W-1:0]        mag;
    logic [XY_W-1:0]        q;
    logic signed [CS_W-1:0] r;
    mag = v[XY_W-1] ? XY_W'(-v) : XY_W'(v);
    q   = (mag + ROUND_HALF) >> 15;
    if (!v[XY_W-1]) begin
      r = (q > MAG_POS) ? Q15_MAX : $signed(q[CS_W-1:0]);
    end else begin
      r = (q > MAG_NEG) ? Q15_MIN : -$signed(q[CS_W-1:0]);
    end
    return r;
  endfunction

  logic signed [CS_W-1:0]  cq;
  logic signed [CS_W-1:0]  sq;
  logic signed [CS_W-1:0]  cos_nxt;
  logic signed [CS_W-1:0]  sin_nxt;
  logic signed [CS_W-1:0]  cos_r;
  logic signed [CS_W-1:0]  sin_r;
  logic [SIDE_W-1:0]       side1_r;

  logic signed [ROT_W-1:0] cos_ext;
  logic signed [ROT_W-1:0] sin_ext;
  logic signed [ROT_W-1:0] cos2_r;
  logic signed [ROT_W-1:0] sin2_r;
  logic signed [ROT_W-1:0] tc_r;
  logic signed [ROT_W-1:0] ts_r;
  logic [SIDE_W-1:0]       side2_r;

  logic signed [ROT_W-1:0] c_half;
  logic signed [ROT_W-1:0] s_half;
  rot_vec_t                rot_nxt;
  rot_vec_t                rot_r;
  logic [SIDE_W-1:0]       side3_r;

  assign cq = round_q15(x_in);
  assign sq = round_q15(y_in);

  always_comb begin
    case (quad_in)
      QUAD_0: begin
        cos_nxt = cq;
        sin_nxt = sq;
      end
      QUAD_1: begin
        cos_nxt = -sq;
        sin_nxt = cq;
      end
      QUAD_2: begin
        cos_nxt = -cq;
        sin_nxt = -sq;
      end
      QUAD_3: begin
        cos_nxt = sq;
        sin_nxt = -cq;
      end
      default: begin
        cos_nxt = cq;
        sin_nxt = sq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      cos_r   <= cos_nxt;
      sin_r   <= sin_nxt;
      side1_r <= side_in;
    end
  end

  assign cos_ext = ROT_W'(cos_r);
  assign sin_ext = ROT_W'(sin_r);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      cos2_r  <= cos_ext;
      sin2_r  <= sin_ext;
      tc_r    <= cos_ext * ROOT3_HALF;
      ts_r    <= sin_ext * ROOT3_HALF;
      side2_r <= side1_r;
    end
  end

  assign c_half = cos2_r <<< 14;
  assign s_half = sin2_r <<< 14;

  always_comb begin
    rot_nxt[0] = cos2_r <<< 15;
    rot_nxt[1] = sin2_r <<< 15;
    rot_nxt[2] = -c_half - ts_r;
    rot_nxt[3] = -s_half + tc_r;
    rot_nxt[4] = -c_half + ts_r;
    rot_nxt[5] = -s_half - tc_r;
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      rot_r   <= rot_nxt;
      side3_r <= side2_r;
    end
  end

  assign rot_out  = rot_r;
  assign side_out = side3_r;

endmodule

`default_nettype wire

// File: design/tsvt_place.sv
// Scaling of the rotated corners, translation, rounding and saturation to screen coordinates.
`default_nettype none

module tsvt_place import tsvt_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic [2:0]                          ld,
  input  rot_vec_t                            rot_in,
  input  logic [SCALE_W-1:0]                  scale_in,
  input  logic signed [COORD_BITS-1:0]        pos_x_in,
  input  logic signed [COORD_BITS-1:0]        pos_y_in,
  output logic [VERT_N-1:0][COORD_BITS-1:0]   vert_out
);

  localparam int HI_W = OFF_W - FRAC_W;
  localparam int WH   = ((COORD_BITS > HI_W) ? COORD_BITS : HI_W) + 2;
  localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [OFF_W-1:0]      scale_ext;
  logic [VERT_N-1:0][OFF_W-1:0] off_r;
  logic signed [COORD_BITS-1:0] px_r;
  logic signed [COORD_BITS-1:0] py_r;

  logic [VERT_N-1:0][WH-1:0]    whole_nxt;
  logic [VERT_N-1:0]            rb_nxt;
  logic [VERT_N-1:0][WH-1:0]    whole_r;
  logic [VERT_N-1:0]            rb_r;

  logic [VERT_N-1:0][COORD_BITS-1:0] vert_nxt;
  logic [VERT_N-1:0][COORD_BITS-1:0] vert_r;

  assign scale_ext = $signed(OFF_W'(scale_in));

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int k = 0; k < VERT_N; k++) begin
        off_r[k] <= OFF_W'($signed(rot_in[k])) * scale_ext;
      end
      px_r <= pos_x_in;
      py_r <= pos_y_in;
    end
  end

  // The integer part of the offset joins the position; the fraction only decides rounding.
  always_comb begin
    for (int k = 0; k < VERT_N; k++) begin
      whole_nxt[k] = ((k % 2 == 0) ? WH'(px_r) : WH'(py_r))
                   + WH'($signed(off_r[k][OFF_W-1:FRAC_W]));
      if (!whole_nxt[k][WH-1]) begin
        rb_nxt[k] = off_r[k][FRAC_W-1];
      end else begin
        rb_nxt[k] = off_r[k][FRAC_W-1] & (|off_r[k][FRAC_W-2:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      whole_r <= whole_nxt;
      rb_r    <= rb_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < VERT_N; k++) begin
      logic [WH-1:0] sum;
      sum = whole_r[k] + WH'(rb_r[k]);
      if ((&sum[WH-1:COORD_BITS-1]) || !(|sum[WH-1:COORD_BITS-1])) begin
        vert_nxt[k] = sum[COORD_BITS-1:0];
      end else begin
        vert_nxt[k] = sum[WH-1] ? COORD_MIN : COORD_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      vert_r <= vert_nxt;
    end
  end

  assign vert_out = vert_r;

endmodule

`default_nettype wire

// File: design/triangle_sprite_vertex_transform.sv
// Top level of the triangle sprite vertex transform pipeline.
`default_nettype none

// Places a fixed unit triangle on screen: each corner is rotated by the heading,
// scaled by the Q12.4 scale, moved by the position and rounded to whole pixels,
// saturating to signed COORD_BITS. The block accepts one pose per clock while the
// output is ready and returns one vertex set per pose, in order. The pipeline is
// made of one capture stage, the 20 CORDIC stages that produce sine and cosine,
// and six stages of rounding, rotation, scaling and placement. Every stage holds
// its own valid bit, so a stalled output only backs up the pipeline until the
// empty stages are filled; input is taken whenever any stage is free or the
// output transfer completes.

module triangle_sprite_vertex_transform import tsvt_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tsvt_in_if.sink    in_ch,
  tsvt_out_if.source out_ch
);

  localparam int STAGES    = 1 + CORDIC_STEPS + 3 + 3;
  localparam int ROT_FIRST = 1 + CORDIC_STEPS;
  localparam int PLC_FIRST = ROT_FIRST + 3;
  localparam int HEAD_KEEP = (ANGLE_BITS < HEAD_W) ? ANGLE_BITS : HEAD_W;
  localparam logic [HEAD_W-1:0] HEAD_MASK = {HEAD_W{1'b1}} << (HEAD_W - HEAD_KEEP);
  localparam int POS_W     = 2 * COORD_BITS;
  localparam int RSIDE_W   = SCALE_W + POS_W;
  localparam int CSIDE_W   = 2 + RSIDE_W;

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] valid_nxt;
  logic [STAGES-1:0] ready;

  logic [HEAD_W-1:0]            head_r;
  logic [SCALE_W-1:0]           scale_r;
  logic signed [COORD_BITS-1:0] posx_r;
  logic signed [COORD_BITS-1:0] posy_r;

  logic signed [Z_W-1:0]  z_start;
  logic [CSIDE_W-1:0]     cside_in;
  logic [CSIDE_W-1:0]     cside_out;
  logic signed [XY_W-1:0] cx;
  logic signed [XY_W-1:0] cy;
  rot_vec_t               rot;
  logic [RSIDE_W-1:0]     rside_out;

  logic [VERT_N-1:0][COORD_BITS-1:0] vert;

  // A stage may load when the output is taken or any stage from it onward is empty.
  for (genvar g = 0; g < STAGES; g++) begin : g_ready
    assign ready[g] = out_ch.ready || !(&valid_r[STAGES-1:g]);
  end

  always_comb begin
    valid_nxt[0] = ready[0] ? in_ch.valid : valid_r[0];
    for (int i = 1; i < STAGES; i++) begin
      valid_nxt[i] = ready[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      head_r  <= in_ch.heading & HEAD_MASK;
      scale_r <= in_ch.scale;
      posx_r  <= in_ch.pos_x;
      posy_r  <= in_ch.pos_y;
    end
  end

  assign z_start  = Z_W'({head_r[HEAD_W-3:0], {(PHASE_W-HEAD_W){1'b0}}});
  assign cside_in = {head_r[HEAD_W-1:HEAD_W-2], scale_r, posx_r, posy_r};

  tsvt_cordic #(
    .SIDE_W (CSIDE_W)
  ) u_cordic (
    .clk      (clk),
    .ld       (ready[ROT_FIRST-1:1]),
    .z_in     (z_start),
    .side_in  (cside_in),
    .x_out    (cx),
    .y_out    (cy),
    .side_out (cside_out)
  );

  tsvt_rotate #(
    .SIDE_W (RSIDE_W)
  ) u_rotate (
    .clk      (clk),
    .ld       (ready[PLC_FIRST-1:ROT_FIRST]),
    .x_in     (cx),
    .y_in     (cy),
    .quad_in  (quad_t'(cside_out[CSIDE_W-1:RSIDE_W])),
    .side_in  (cside_out[RSIDE_W-1:0]),
    .rot_out  (rot),
    .side_out (rside_out)
  );

  tsvt_place #(
    .COORD_BITS (COORD_BITS)
  ) u_place (
    .clk      (clk),
    .ld       (ready[STAGES-1:PLC_FIRST]),
    .rot_in   (rot),
    .scale_in (rside_out[RSIDE_W-1:POS_W]),
    .pos_x_in (rside_out[POS_W-1:COORD_BITS]),
    .pos_y_in (rside_out[COORD_BITS-1:0]),
    .vert_out (vert)
  );

  assign in_ch.ready  = ready[0];
  assign out_ch.valid = valid_r[STAGES-1];
  assign out_ch.vx0   = vert[0];
  assign out_ch.vy0   = vert[1];
  assign out_ch.vx1   = vert[2];
  assign out_ch.vy1   = vert[3];
  assign out_ch.vx2   = vert[4];
  assign out_ch.vy2   = vert[5];

  // An input transfer always lands in the capture stage.
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> valid_r[0])
    else $error("input transfer did not reach the capture stage");

  // A free output never blocks the input.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while the output was ready");

  // Any bubble in the pipeline lets a new item in.
  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !(&valid_r) |-> in_ch.ready)
    else $error("input stalled although a pipeline stage was empty");

endmodule

`default_nettype wire
